// File: sv/mra_pkg.sv
// shared types, codes and helpers of the mixed-radix signed arithmetic unit
// no dependencies
package mra_pkg;

	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_MUL  = 3'd2;
	localparam logic [2:0] CMD_DIV  = 3'd3;
	localparam logic [2:0] CMD_FROMI = 3'd4;
	localparam logic [2:0] CMD_TOI  = 3'd5;

	localparam int MAG_W = 23;
	localparam int NUM_W = 46;
	localparam int DIV_STEPS = 3;
	localparam logic [MAG_W-1:0] MODULUS = 23'd4320000;

	typedef struct packed {
		logic [2:0]       cmd;
		logic             sa;
		logic             sx;
		logic [23:0]      ires;
		logic [NUM_W-1:0] nq;
		logic [MAG_W:0]   rem;
		logic [MAG_W-1:0] den;
	} div_item_t;

	// exact for v below 6553600
	function automatic logic [15:0] div100(input logic [MAG_W-1:0] v);
		logic [48:0] p;
		p = 49'(v) * 49'd42949673;
		return p[47:32];
	endfunction

	// exact for t below 61440
	function automatic logic [9:0] div60(input logic [15:0] t);
		logic [34:0] p;
		p = 35'(t) * 35'd279621;
		return p[33:24];
	endfunction

endpackage

// File: sv/mra_front.sv
// operand decode: magnitudes, then sum, difference, product, divider and integer-conversion operands
// depends on mra_pkg
module mra_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0]            cmd,
	input  logic                  a_sign,
	input  logic [3:0]            a_hours,
	input  logic [5:0]            a_minutes,
	input  logic [5:0]            a_seconds,
	input  logic [6:0]            a_millis,
	input  logic                  b_sign,
	input  logic [3:0]            b_hours,
	input  logic [5:0]            b_minutes,
	input  logic [5:0]            b_seconds,
	input  logic [6:0]            b_millis,
	input  logic [31:0]           int_value,
	output logic                  valid_s2,
	output mra_pkg::div_item_t    item_s2
);
	import mra_pkg::*;

	logic             valid_s1;
	logic [2:0]       cmd_s1;
	logic             sa_s1, sb_s1;
	logic [MAG_W-1:0] ma_s1, mb_s1;
	logic [31:0]      iv_s1;

	logic [MAG_W-1:0] ma, mb, diff;
	logic [MAG_W:0]   sum;
	logic [NUM_W-1:0] prod;
	logic [31:0]      iabs;
	logic             ge, do_add;
	div_item_t        nxt;

	assign ma = 23'(a_hours) * 23'd360000 + 23'(a_minutes) * 23'd6000
		+ 23'(a_seconds) * 23'd100 + 23'(a_millis);
	assign mb = 23'(b_hours) * 23'd360000 + 23'(b_minutes) * 23'd6000
		+ 23'(b_seconds) * 23'd100 + 23'(b_millis);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= cmd;
			sa_s1   <= a_sign;
			sb_s1   <= b_sign;
			ma_s1   <= ma;
			mb_s1   <= mb;
			iv_s1   <= int_value;
			item_s2 <= nxt;
		end
	end

	always_comb begin
		sum    = {1'b0, ma_s1} + {1'b0, mb_s1};
		ge     = ma_s1 >= mb_s1;
		diff   = ge ? ma_s1 - mb_s1 : mb_s1 - ma_s1;
		prod   = NUM_W'(ma_s1) * NUM_W'(mb_s1);
		iabs   = iv_s1[31] ? 32'd0 - iv_s1 : iv_s1;
		do_add = (cmd_s1 == CMD_ADD) ? (sa_s1 == sb_s1) : (sa_s1 != sb_s1);
		nxt      = '0;
		nxt.cmd  = cmd_s1;
		nxt.sa   = sa_s1;
		nxt.den  = MODULUS;
		case (cmd_s1)
			CMD_ADD, CMD_SUB: begin
				nxt.nq = do_add ? NUM_W'(sum) : NUM_W'(diff);
				nxt.sx = (do_add || ge) ? sa_s1 : ~sa_s1;
			end
			CMD_MUL: begin
				nxt.nq = prod;
				nxt.sx = sa_s1 ^ sb_s1;
			end
			CMD_DIV: begin
				nxt.nq  = NUM_W'(ma_s1);
				nxt.den = mb_s1;
				nxt.sx  = sa_s1 ^ sb_s1;
			end
			CMD_FROMI: begin
				nxt.nq = NUM_W'(iabs);
				nxt.sx = iv_s1[31];
			end
			CMD_TOI: begin
				nxt.ires = sa_s1 ? 24'd0 - 24'(ma_s1) : 24'(ma_s1);
			end
			default: begin
				nxt.cmd = cmd_s1;
			end
		endcase
	end

endmodule

// File: sv/mra_divstage.sv
// one stage of the restoring divider, STEPS quotient bits per stage
// depends on mra_pkg
module mra_divstage #(
	parameter int STEPS = mra_pkg::DIV_STEPS,
	parameter int BASE  = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  mra_pkg::div_item_t in_item,
	output logic               out_valid,
	output mra_pkg::div_item_t out_item
);
	import mra_pkg::*;

	div_item_t        nxt;
	logic [MAG_W:0]   r2;
	logic             ge;

	always_comb begin
		nxt = in_item;
		r2  = '0;
		ge  = 1'b0;
		for (int j = 0; j < STEPS; j++) begin
			if (BASE + j < NUM_W) begin
				r2      = {nxt.rem[MAG_W-1:0], nxt.nq[NUM_W-1]};
				ge      = r2 >= {1'b0, nxt.den};
				nxt.rem = ge ? r2 - {1'b0, nxt.den} : r2;
				nxt.nq  = {nxt.nq[NUM_W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item <= nxt;
		end
	end

endmodule

// File: sv/mra_split.sv
// result fixup and signs, then digit split by reciprocal multiplies
// depends on mra_pkg
module mra_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  mra_pkg::div_item_t in_item,
	output logic               out_valid,
	output logic               status,
	output logic               q_sign,
	output logic [3:0]         q_hours,
	output logic [5:0]         q_minutes,
	output logic [5:0]         q_seconds,
	output logic [6:0]         q_millis,
	output logic               r_sign,
	output logic [3:0]         r_hours,
	output logic [5:0]         r_minutes,
	output logic [5:0]         r_seconds,
	output logic [6:0]         r_millis,
	output logic [23:0]        int_result
);
	import mra_pkg::*;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic             st_s1, st_s2, st_s3, st_s4;
	logic             qs_s1, qs_s2, qs_s3, qs_s4;
	logic             rs_s1, rs_s2, rs_s3, rs_s4;
	logic [23:0]      ir_s1, ir_s2, ir_s3, ir_s4;
	logic [MAG_W-1:0] qv_s1, rv_s1, qv_s2, rv_s2;
	logic [15:0]      qt_s2, rt_s2, qt_s3, rt_s3;
	logic [9:0]       qm_s3, rm_s3, qm_s4, rm_s4;
	logic [6:0]       qms_s3, rms_s3, qms_s4, rms_s4;
	logic [5:0]       qsec_s4, rsec_s4;
	logic [3:0]       qu_s4, ru_s4;

	logic [MAG_W-1:0] qm, rm, qv, rv;
	logic             st, qs, rs;
	logic [23:0]      ir;

	always_comb begin
		qm = in_item.nq[MAG_W-1:0];
		rm = in_item.rem[MAG_W-1:0];
		qv = '0;
		rv = '0;
		st = 1'b0;
		qs = 1'b0;
		rs = 1'b0;
		ir = '0;
		case (in_item.cmd)
			CMD_ADD, CMD_SUB, CMD_FROMI: begin
				qv = rm;
				qs = in_item.sx;
			end
			CMD_MUL: begin
				qv = rm;
				qs = in_item.sx && (rm != '0);
			end
			CMD_DIV: begin
				if (in_item.den == '0) begin
					st = 1'b1;
				end else begin
					qv = (qm >= MODULUS) ? qm - MODULUS : qm;
					rv = (rm >= MODULUS) ? rm - MODULUS : rm;
					qs = in_item.sx && (qm != '0);
					rs = in_item.sa && (rm != '0);
				end
			end
			CMD_TOI: begin
				ir = in_item.ires;
			end
			default: begin
				st = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st;
			qs_s1 <= qs;
			rs_s1 <= rs;
			ir_s1 <= ir;
			qv_s1 <= qv;
			rv_s1 <= rv;

			st_s2 <= st_s1;
			qs_s2 <= qs_s1;
			rs_s2 <= rs_s1;
			ir_s2 <= ir_s1;
			qv_s2 <= qv_s1;
			rv_s2 <= rv_s1;
			qt_s2 <= div100(qv_s1);
			rt_s2 <= div100(rv_s1);

			st_s3  <= st_s2;
			qs_s3  <= qs_s2;
			rs_s3  <= rs_s2;
			ir_s3  <= ir_s2;
			qt_s3  <= qt_s2;
			rt_s3  <= rt_s2;
			qms_s3 <= 7'(qv_s2 - 23'(qt_s2) * 23'd100);
			rms_s3 <= 7'(rv_s2 - 23'(rt_s2) * 23'd100);
			qm_s3  <= div60(qt_s2);
			rm_s3  <= div60(rt_s2);

			st_s4   <= st_s3;
			qs_s4   <= qs_s3;
			rs_s4   <= rs_s3;
			ir_s4   <= ir_s3;
			qms_s4  <= qms_s3;
			rms_s4  <= rms_s3;
			qm_s4   <= qm_s3;
			rm_s4   <= rm_s3;
			qsec_s4 <= 6'(qt_s3 - 16'(qm_s3) * 16'd60);
			rsec_s4 <= 6'(rt_s3 - 16'(rm_s3) * 16'd60);
			qu_s4   <= 4'(div60(16'(qm_s3)));
			ru_s4   <= 4'(div60(16'(rm_s3)));

			status     <= st_s4;
			q_sign     <= qs_s4;
			r_sign     <= rs_s4;
			int_result <= ir_s4;
			q_millis   <= qms_s4;
			r_millis   <= rms_s4;
			q_seconds  <= qsec_s4;
			r_seconds  <= rsec_s4;
			q_minutes  <= 6'(qm_s4 - 10'(qu_s4) * 10'd60);
			r_minutes  <= 6'(rm_s4 - 10'(ru_s4) * 10'd60);
			q_hours    <= qu_s4;
			r_hours    <= ru_s4;
		end
	end

endmodule

// File: sv/mixed_radix_signed_alu.sv
// mixed-radix signed arithmetic unit, top level
// one item per cycle while the output item is not held
// the restoring divider chain computes DIV_STEPS quotient bits per stage
// the whole pipeline holds while the output item waits
// arst_n clears all valid bits, payload registers are not reset
// depends on mra_pkg, mra_front, mra_divstage, mra_split
module mixed_radix_signed_alu #(
	parameter int DIV_STEPS = mra_pkg::DIV_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// a_sign, a_hours, a_minutes, a_seconds, a_millis,
	// b_sign, b_hours, b_minutes, b_seconds, b_millis, int_value
	input  logic [79:0] s_tdata,
	// cmd
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// q_sign, q_hours, q_minutes, q_seconds, q_millis,
	// r_sign, r_hours, r_minutes, r_seconds, r_millis, int_result
	output logic [71:0] m_tdata,
	// status
	output logic        m_tuser
);
	import mra_pkg::*;

	localparam int STAGES = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;

	logic        en;
	logic        dv [STAGES+1];
	div_item_t   di [STAGES+1];
	logic [23:0] int_result_w;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tdata[71:48] = int_result_w;

	mra_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.cmd       (s_tuser),
		.a_sign    (s_tdata[0]),
		.a_hours   (s_tdata[4:1]),
		.a_minutes (s_tdata[10:5]),
		.a_seconds (s_tdata[16:11]),
		.a_millis  (s_tdata[23:17]),
		.b_sign    (s_tdata[24]),
		.b_hours   (s_tdata[28:25]),
		.b_minutes (s_tdata[34:29]),
		.b_seconds (s_tdata[40:35]),
		.b_millis  (s_tdata[47:41]),
		.int_value (s_tdata[79:48]),
		.valid_s2  (dv[0]),
		.item_s2   (di[0])
	);

	for (genvar k = 0; k < STAGES; k++) begin : g_div
		mra_divstage #(
			.STEPS (DIV_STEPS),
			.BASE  (k * DIV_STEPS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv[k]),
			.in_item   (di[k]),
			.out_valid (dv[k+1]),
			.out_item  (di[k+1])
		);
	end

	mra_split u_split (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (dv[STAGES]),
		.in_item    (di[STAGES]),
		.out_valid  (m_tvalid),
		.status     (m_tuser),
		.q_sign     (m_tdata[0]),
		.q_hours    (m_tdata[4:1]),
		.q_minutes  (m_tdata[10:5]),
		.q_seconds  (m_tdata[16:11]),
		.q_millis   (m_tdata[23:17]),
		.r_sign     (m_tdata[24]),
		.r_hours    (m_tdata[28:25]),
		.r_minutes  (m_tdata[34:29]),
		.r_seconds  (m_tdata[40:35]),
		.r_millis   (m_tdata[47:41]),
		.int_result (int_result_w)
	);

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output item stalled");

	a_divzero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("division by zero item carries nonzero fields");

	a_digits_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:1] < 4'd12 && m_tdata[10:5] < 6'd60
			&& m_tdata[16:11] < 6'd60 && m_tdata[23:17] < 7'd100
			&& m_tdata[28:25] < 4'd12 && m_tdata[34:29] < 6'd60
			&& m_tdata[40:35] < 6'd60 && m_tdata[47:41] < 7'd100)
		else $error("result digit out of radix");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the mixed-radix signed arithmetic unit
// drives directed and random operations through the stream ports, predicts each result
// depends on mra_pkg and mixed_radix_signed_alu
`timescale 1ns / 100ps

module tb_top;
	import mra_pkg::*;

	localparam int MOD = 4320000;
	localparam int LATENCY = 23;
	localparam int LIMIT = 400000;
	localparam int N_RANDOM = 530;

	typedef struct {
		logic [2:0]  cmd;
		logic        sa;
		logic [3:0]  ah;
		logic [5:0]  am;
		logic [5:0]  as_;
		logic [6:0]  ams;
		logic        sb;
		logic [3:0]  bh;
		logic [5:0]  bm;
		logic [5:0]  bs;
		logic [6:0]  bms;
		logic [31:0] ival;
	} op_t;

	typedef struct packed {
		logic        status;
		logic [22:0] qd;
		logic [22:0] rd;
		logic        qs;
		logic        rs;
		logic [23:0] ires;
	} res_t;

	typedef struct {
		op_t  op;
		logic known;
		res_t res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [79:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [71:0] m_tdata;
	logic m_tuser;

	res_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	bit rx_calm = 0;
	bit tx_calm = 0;

	mixed_radix_signed_alu dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// digits of a magnitude, packed q order: ms, s, m, h
	function automatic logic [22:0] digits(input longint unsigned mag);
		longint unsigned v;
		logic [22:0] d;
		v = mag % MOD;
		d[6:0] = 7'(v % 100);
		v = v / 100;
		d[12:7] = 6'(v % 60);
		v = v / 60;
		d[18:13] = 6'(v % 60);
		v = v / 60;
		d[22:19] = 4'(v % 12);
		return d;
	endfunction

	function automatic longint unsigned mag_of(input logic [3:0] h, input logic [5:0] m,
			input logic [5:0] s, input logic [6:0] ms);
		return ((longint'(h) * 60 + m) * 60 + s) * 100 + ms;
	endfunction

	function automatic res_t alu_result(input op_t op);
		res_t r;
		longint unsigned ma, mb, p, qm, rm;
		logic [31:0] v;
		r = '{default: '0};
		ma = mag_of(op.ah, op.am, op.as_, op.ams);
		mb = mag_of(op.bh, op.bm, op.bs, op.bms);
		case (op.cmd)
			CMD_ADD, CMD_SUB: begin
				if ((op.cmd == CMD_ADD) == (op.sa == op.sb)) begin
					r.qs = op.sa;
					r.qd = digits(ma + mb);
				end else if (ma >= mb) begin
					r.qs = op.sa;
					r.qd = digits(ma - mb);
				end else begin
					r.qs = ~op.sa;
					r.qd = digits(mb - ma);
				end
			end
			CMD_MUL: begin
				p = (ma * mb) % MOD;
				r.qs = (op.sa ^ op.sb) && p != 0;
				r.qd = digits(p);
			end
			CMD_DIV: begin
				if (mb == 0) r.status = 1'b1;
				else begin
					qm = ma / mb;
					rm = ma % mb;
					r.qs = (op.sa ^ op.sb) && qm != 0;
					r.qd = digits(qm);
					r.rs = op.sa && rm != 0;
					r.rd = digits(rm);
				end
			end
			CMD_FROMI: begin
				v = op.ival;
				r.qs = v[31];
				r.qd = digits(v[31] ? 32'(0 - v) : v);
			end
			CMD_TOI: r.ires = op.sa ? 24'(0 - ma) : 24'(ma);
			default: ;
		endcase
		return r;
	endfunction

	function automatic op_t random_op();
		op_t op;
		op.cmd = $urandom_range(0, 99) < 3 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
		op.sa = 1'($urandom);
		op.sb = 1'($urandom);
		op.ival = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			// out-of-range digits
			{op.ah, op.am, op.as_, op.ams} = 23'($urandom);
			{op.bh, op.bm, op.bs, op.bms} = 23'($urandom);
		end else begin
			op.ah = 4'($urandom_range(0, 11));
			op.am = 6'($urandom_range(0, 59));
			op.as_ = 6'($urandom_range(0, 59));
			op.ams = 7'($urandom_range(0, 99));
			op.bh = 4'($urandom_range(0, 11));
			op.bm = 6'($urandom_range(0, 59));
			op.bs = 6'($urandom_range(0, 59));
			op.bms = 7'($urandom_range(0, 99));
		end
		case ($urandom_range(0, 9))
			0: {op.bh, op.bm, op.bs, op.bms} = '0;
			1: begin
				op.bh = '0;
				op.bm = '0;
				op.bs = 6'($urandom_range(0, 2));
			end
			2: {op.bh, op.bm, op.bs, op.bms} = {op.ah, op.am, op.as_, op.ams};
			default: ;
		endcase
		return op;
	endfunction

	task automatic send(input op_t op);
		s_tvalid <= 1;
		s_tuser <= op.cmd;
		s_tdata <= {op.ival, op.bms, op.bs, op.bm, op.bh, op.sb,
			op.ams, op.as_, op.am, op.ah, op.sa};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(alu_result(op));
		if (!tx_calm) while ($urandom_range(0, 99) < 10) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic check_row(input row_t row);
		res_t p;
		p = alu_result(row.op);
		if (row.known && p != row.res) begin
			$error("table row mismatch: cmd %0d typed %p predicted %p", row.op.cmd, row.res, p);
			errors++;
		end
	endtask

	// receive side
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = pending_results.pop_front();
					if (m_tuser !== e.status) begin
						$error("status exp %0d got %0d", e.status, m_tuser);
						errors++;
					end
					if (m_tdata[0] !== e.qs) begin
						$error("q_sign exp %0d got %0d", e.qs, m_tdata[0]);
						errors++;
					end
					if (m_tdata[4:1] !== e.qd[22:19]) begin
						$error("q_hours exp %0d got %0d", e.qd[22:19], m_tdata[4:1]);
						errors++;
					end
					if (m_tdata[10:5] !== e.qd[18:13]) begin
						$error("q_minutes exp %0d got %0d", e.qd[18:13], m_tdata[10:5]);
						errors++;
					end
					if (m_tdata[16:11] !== e.qd[12:7]) begin
						$error("q_seconds exp %0d got %0d", e.qd[12:7], m_tdata[16:11]);
						errors++;
					end
					if (m_tdata[23:17] !== e.qd[6:0]) begin
						$error("q_millis exp %0d got %0d", e.qd[6:0], m_tdata[23:17]);
						errors++;
					end
					if (m_tdata[24] !== e.rs) begin
						$error("r_sign exp %0d got %0d", e.rs, m_tdata[24]);
						errors++;
					end
					if (m_tdata[28:25] !== e.rd[22:19]) begin
						$error("r_hours exp %0d got %0d", e.rd[22:19], m_tdata[28:25]);
						errors++;
					end
					if (m_tdata[34:29] !== e.rd[18:13]) begin
						$error("r_minutes exp %0d got %0d", e.rd[18:13], m_tdata[34:29]);
						errors++;
					end
					if (m_tdata[40:35] !== e.rd[12:7]) begin
						$error("r_seconds exp %0d got %0d", e.rd[12:7], m_tdata[40:35]);
						errors++;
					end
					if (m_tdata[47:41] !== e.rd[6:0]) begin
						$error("r_millis exp %0d got %0d", e.rd[6:0], m_tdata[47:41]);
						errors++;
					end
					if (m_tdata[71:48] !== e.ires) begin
						$error("int_result exp %0d got %0d", $signed(e.ires),
							$signed(m_tdata[71:48]));
						errors++;
					end
				end
			end
			m_tready <= rx_calm ? 1'b1 : ($urandom_range(0, 99) >= 10);
		end
	end

	row_t directed[$];

	initial begin
		op_t op;
		res_t r;
		int wait_cycles;
		op = '{default: '0};
		r = '{default: '0};
		// zero plus zero
		op.cmd = CMD_ADD;
		directed.push_back('{op, 1, r});
		// largest plus one wraps to zero
		op = '{cmd: CMD_ADD, ah: 11, am: 59, as_: 59, ams: 99, bms: 1, default: '0};
		directed.push_back('{op, 1, r});
		// add with unequal signs
		op = '{cmd: CMD_ADD, sa: 1, ah: 1, bm: 1, default: '0};
		directed.push_back('{op, 0, r});
		// equal magnitudes keep a's sign
		op = '{cmd: CMD_SUB, sa: 1, sb: 1, am: 5, bm: 5, default: '0};
		r.qs = 1'b1;
		directed.push_back('{op, 1, r});
		op = '{cmd: CMD_SUB, bh: 2, ams: 7, default: '0};
		directed.push_back('{op, 0, r});
		op = '{cmd: CMD_SUB, sb: 1, ah: 11, am: 59, as_: 59, ams: 99,
			bh: 11, bm: 59, bs: 59, bms: 99, default: '0};
		directed.push_back('{op, 0, r});
		// product wrapping to zero stays positive
		op = '{cmd: CMD_MUL, sb: 1, ah: 1, bm: 12, default: '0};
		r = '{default: '0};
		directed.push_back('{op, 1, r});
		op = '{cmd: CMD_MUL, sa: 1, ah: 11, am: 59, as_: 59, ams: 99,
			bh: 11, bm: 59, bs: 59, bms: 99, default: '0};
		directed.push_back('{op, 0, r});
		// division by zero, both signs
		op = '{cmd: CMD_DIV, sa: 1, ah: 3, sb: 1, default: '0};
		r.status = 1'b1;
		directed.push_back('{op, 1, r});
		op = '{cmd: CMD_DIV, ah: 11, default: '0};
		directed.push_back('{op, 1, r});
		op = '{cmd: CMD_DIV, sa: 1, ah: 11, am: 59, as_: 59, ams: 99, sb: 0, bms: 7,
			default: '0};
		directed.push_back('{op, 0, r});
		op = '{cmd: CMD_DIV, sa: 1, ams: 3, sb: 1, bh: 1, default: '0};
		directed.push_back('{op, 0, r});
		// out-of-range digits
		op = '{cmd: CMD_DIV, ah: 15, am: 63, as_: 63, ams: 127, bms: 1, default: '0};
		directed.push_back('{op, 0, r});
		op = '{cmd: CMD_FROMI, ival: 32'h80000000, default: '0};
		directed.push_back('{op, 0, r});
		op = '{cmd: CMD_FROMI, ival: 32'h7fffffff, default: '0};
		directed.push_back('{op, 0, r});
		// negative multiple of the modulus gives negative zero
		op = '{cmd: CMD_FROMI, ival: -32'sd4320000, default: '0};
		r = '{default: '0};
		r.qs = 1'b1;
		directed.push_back('{op, 1, r});
		op = '{cmd: CMD_FROMI, ival: 32'hffffffff, default: '0};
		directed.push_back('{op, 0, r});
		// negative zero converts to zero
		op = '{cmd: CMD_TOI, sa: 1, default: '0};
		r = '{default: '0};
		directed.push_back('{op, 1, r});
		op = '{cmd: CMD_TOI, sa: 1, ah: 15, am: 63, as_: 63, ams: 127, default: '0};
		directed.push_back('{op, 0, r});
		op = '{cmd: CMD_TOI, ah: 11, am: 59, as_: 59, ams: 99, default: '0};
		r.ires = 24'd4319999;
		directed.push_back('{op, 1, r});
		// unused commands give all zero
		op = '{cmd: 3'd6, sa: 1, ah: 5, ival: 32'hffffffff, default: '0};
		r = '{default: '0};
		directed.push_back('{op, 1, r});
		op = '{cmd: 3'd7, sb: 1, bh: 5, bms: 99, default: '0};
		directed.push_back('{op, 1, r});

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) begin
			check_row(directed[i]);
			send(directed[i].op);
		end
		s_tvalid <= 0;
		// hold off until the pipeline drains
		while (pending_results.size() != 0) @(posedge clk);
		for (int i = 0; i < N_RANDOM; i++) begin
			tx_calm = (i >= 200 && i < 300);
			rx_calm = (i >= 220 && i < 300);
			send(random_op());
		end
		s_tvalid <= 0;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
